@@ hdl/tlps_pkg.sv @@
// Shared types, register indexes and lamp patterns of the traffic light phase sequencer.
`timescale 1ns / 1ps

package tlps_pkg;

  localparam int unsigned DurW = 16;
  localparam int unsigned LampW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned BlinkW = 4;

  typedef enum logic [2:0] {
    PH_RED        = 3'd0,
    PH_RED_YELLOW = 3'd1,
    PH_GREEN      = 3'd2,
    PH_BLINK      = 3'd3,
    PH_YELLOW     = 3'd4
  } phase_t;

  localparam logic [CfgIdxW-1:0] REG_RED        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RED_YELLOW = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GREEN      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLINK_STEP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_YELLOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_START      = 3'd5;

  localparam logic [DurW-1:0] RST_RED        = 16'd12000;
  localparam logic [DurW-1:0] RST_RED_YELLOW = 16'd2000;
  localparam logic [DurW-1:0] RST_GREEN      = 16'd7000;
  localparam logic [DurW-1:0] RST_BLINK_STEP = 16'd500;
  localparam logic [DurW-1:0] RST_YELLOW     = 16'd3000;
  localparam logic [DurW-1:0] RST_START      = 16'd750;

  localparam logic [BlinkW-1:0] BLINK_FIRST = 4'd2;
  localparam logic [BlinkW-1:0] BLINK_LAST  = 4'd9;

  localparam logic [LampW-1:0] MAIN_OFF        = 3'd0;
  localparam logic [LampW-1:0] MAIN_RED        = 3'd4;
  localparam logic [LampW-1:0] MAIN_RED_YELLOW = 3'd6;
  localparam logic [LampW-1:0] MAIN_GREEN      = 3'd1;
  localparam logic [LampW-1:0] MAIN_YELLOW     = 3'd2;
  localparam logic [LampW-1:0] AUX_IDLE        = 3'd7;
  localparam logic [LampW-1:0] AUX_RED         = 3'd3;
  localparam logic [LampW-1:0] AUX_GO          = 3'd6;
  localparam logic [LampW-1:0] AUX_YELLOW      = 3'd4;

  typedef struct packed {
    logic [DurW-1:0] red;
    logic [DurW-1:0] red_yellow;
    logic [DurW-1:0] green;
    logic [DurW-1:0] blink_step;
    logic [DurW-1:0] yellow;
  } dur_t;

  typedef struct packed {
    logic            reload;
    logic [DurW-1:0] value;
  } start_load_t;

  typedef struct packed {
    logic [LampW-1:0] main_lamps;
    logic [LampW-1:0] aux_lamps_n;
    logic [2:0]       phase;
    logic             changed;
  } result_t;

  function automatic logic [DurW-1:0] at_least_one(input logic [DurW-1:0] v);
    at_least_one = (v == '0) ? DurW'(1) : v;
  endfunction

endpackage

@@ hdl/tlps_cfg_regs.sv @@
// Configuration register file holding the phase durations; the start delay is passed on as a reload.
`timescale 1ns / 1ps

module tlps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tlps_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [tlps_pkg::DurW-1:0]     wr_data,
  output tlps_pkg::dur_t                durations,
  output tlps_pkg::start_load_t         start_load
);
  import tlps_pkg::*;

  dur_t dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r.red        <= RST_RED;
      dur_r.red_yellow <= RST_RED_YELLOW;
      dur_r.green      <= RST_GREEN;
      dur_r.blink_step <= RST_BLINK_STEP;
      dur_r.yellow     <= RST_YELLOW;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RED:        dur_r.red        <= wr_data;
        REG_RED_YELLOW: dur_r.red_yellow <= wr_data;
        REG_GREEN:      dur_r.green      <= wr_data;
        REG_BLINK_STEP: dur_r.blink_step <= wr_data;
        REG_YELLOW:     dur_r.yellow     <= wr_data;
        default: ;
      endcase
    end
  end

  // The start delay only matters before the first phase change, so it is
  // passed straight on as a countdown reload.
  assign durations         = dur_r;
  assign start_load.reload = wr_en && (wr_index == REG_START);
  assign start_load.value  = wr_data;

endmodule

@@ hdl/tlps_core.sv @@
// Countdown, phase sequencing and lamp pattern state, updated by accepted tick beats and start delay reloads.
`timescale 1ns / 1ps

module tlps_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  tick,
  input  tlps_pkg::dur_t        durations,
  input  tlps_pkg::start_load_t start_load,
  output tlps_pkg::result_t     result
);
  import tlps_pkg::*;

  logic [2:0]        phase_r, phase_nxt;
  logic [DurW-1:0]   remain_r, remain_nxt;
  logic [BlinkW-1:0] blink_r, blink_nxt;
  logic [LampW-1:0]  main_r, main_nxt;
  logic [LampW-1:0]  aux_r, aux_nxt;
  logic              change;

  assign change = step_en && tick && (remain_r <= DurW'(1));

  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    blink_nxt  = blink_r;
    main_nxt   = main_r;
    aux_nxt    = aux_r;
    if (change) begin
      unique case (phase_r)
        PH_RED_YELLOW: begin
          main_nxt   = MAIN_RED_YELLOW;
          aux_nxt    = AUX_GO;
          remain_nxt = at_least_one(durations.red_yellow);
          phase_nxt  = PH_GREEN;
        end
        PH_GREEN: begin
          main_nxt   = MAIN_GREEN;
          aux_nxt    = AUX_GO;
          remain_nxt = at_least_one(durations.green);
          phase_nxt  = PH_BLINK;
        end
        PH_BLINK: begin
          main_nxt   = {{(LampW-1){1'b0}}, blink_r[0]};
          aux_nxt    = AUX_GO;
          remain_nxt = at_least_one(durations.blink_step);
          if (blink_r >= BLINK_LAST) begin
            phase_nxt = PH_YELLOW;
            blink_nxt = BLINK_FIRST;
          end else begin
            blink_nxt = blink_r + BlinkW'(1);
          end
        end
        PH_YELLOW: begin
          main_nxt   = MAIN_YELLOW;
          aux_nxt    = AUX_YELLOW;
          remain_nxt = at_least_one(durations.yellow);
          phase_nxt  = PH_RED;
        end
        default: begin
          main_nxt   = MAIN_RED;
          aux_nxt    = AUX_RED;
          remain_nxt = at_least_one(durations.red);
          phase_nxt  = PH_RED_YELLOW;
        end
      endcase
    end else if (step_en && tick) begin
      remain_nxt = remain_r - DurW'(1);
    end else if (start_load.reload && (aux_r == AUX_IDLE)) begin
      remain_nxt = at_least_one(start_load.value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RED;
      remain_r <= RST_START;
      blink_r  <= BLINK_FIRST;
      main_r   <= MAIN_OFF;
      aux_r    <= AUX_IDLE;
    end else begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      blink_r  <= blink_nxt;
      main_r   <= main_nxt;
      aux_r    <= aux_nxt;
    end
  end

  assign result.main_lamps  = main_nxt;
  assign result.aux_lamps_n = aux_nxt;
  assign result.phase       = phase_nxt;
  assign result.changed     = change;

endmodule

@@ hdl/tlps_out_buf.sv @@
// Two-entry output register with skid slot for the result channel.
`timescale 1ns / 1ps

module tlps_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlps_pkg::result_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output tlps_pkg::result_t out_data,
  output logic              full
);
  import tlps_pkg::*;

  logic    main_v_r, skid_v_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop = main_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r   <= push_data;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= push_data;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign full      = skid_v_r;

endmodule

@@ hdl/traffic_light_phase_sequencer_top.sv @@
// Top level of the traffic light phase sequencer.
// Throughput: one input beat per cycle while in_stall is low. The state update and lamp
// decode finish in the accepting cycle and the result is registered in the output buffer.
// A two-entry output buffer keeps input accepted while one result waits on a stalled output.
// Reset (synchronous, rst_n low): durations return to their defaults, phase is red,
// all lamps are off and the countdown holds the start delay; configuration is always ready.
`timescale 1ns / 1ps

module traffic_light_phase_sequencer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlps_pkg::LampW-1:0]    out_main_lamps,
  output logic [tlps_pkg::LampW-1:0]    out_aux_lamps_n,
  output logic [2:0]                    out_phase,
  output logic                          out_changed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tlps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tlps_pkg::DurW-1:0]     cfg_data
);
  import tlps_pkg::*;

  dur_t        durations;
  start_load_t start_load;
  result_t     step_result;
  result_t     out_data;
  logic        in_accept;
  logic        buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  tlps_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .durations  (durations),
    .start_load (start_load)
  );

  tlps_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .tick       (in_tick),
    .durations  (durations),
    .start_load (start_load),
    .result     (step_result)
  );

  tlps_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign out_main_lamps  = out_data.main_lamps;
  assign out_aux_lamps_n = out_data.aux_lamps_n;
  assign out_phase       = out_data.phase;
  assign out_changed     = out_data.changed;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase <= 3'd4))
    else $error("result phase out of range");

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid slot filled while output register is empty");

  a_change_lights: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_changed) |-> (out_aux_lamps_n != AUX_IDLE))
    else $error("phase change left the auxiliary lamps idle");

  a_no_tick_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_tick && !out_valid) |=> (out_valid && !out_changed))
    else $error("beat without a tick reported a phase change");

endmodule

@@ sim/traffic_light_phase_sequencer_top_tb.sv @@
// Self-checking testbench that drives tick beats and checks every lamp beat against a predictor.
`timescale 1ns / 1ps

module traffic_light_phase_sequencer_top_tb;
  import tlps_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_BEATS = 80;
  localparam int unsigned DIRECTED_BEATS = 20;
  localparam logic [DIRECTED_BEATS-1:0] DIRECTED_TICKS = 20'b1111_1111_1111_1101_1010;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_tick = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LampW-1:0]   out_main_lamps;
  logic [LampW-1:0]   out_aux_lamps_n;
  logic [2:0]         out_phase;
  logic               out_changed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DurW-1:0]    cfg_data = '0;

  // Predictor state of the light sequence.
  logic [DurW-1:0]   light_durs [0:5];
  phase_t            light_phase;
  logic [DurW-1:0]   light_countdown;
  logic [BlinkW-1:0] light_blink;
  logic [LampW-1:0]  light_main;
  logic [LampW-1:0]  light_aux;

  logic        tick_q [$];
  result_t     lamp_expect_q [$];
  result_t     lamp_want;
  logic        in_taken = 1'b0;
  bit          gaps_on = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  traffic_light_phase_sequencer_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tick         (in_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_main_lamps  (out_main_lamps),
    .out_aux_lamps_n (out_aux_lamps_n),
    .out_phase       (out_phase),
    .out_changed     (out_changed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t step_light(input logic tick);
    result_t r;
    phase_t  ph;
    r.changed = 1'b0;
    if (tick) begin
      if (light_countdown <= DurW'(1)) begin
        ph = light_phase;
        light_countdown = (light_durs[ph] == '0) ? DurW'(1) : light_durs[ph];
        r.changed = 1'b1;
        case (ph)
          PH_RED: begin
            light_main = MAIN_RED;
            light_aux = AUX_RED;
            light_phase = PH_RED_YELLOW;
          end
          PH_RED_YELLOW: begin
            light_main = MAIN_RED_YELLOW;
            light_aux = AUX_GO;
            light_phase = PH_GREEN;
          end
          PH_GREEN: begin
            light_main = MAIN_GREEN;
            light_aux = AUX_GO;
            light_phase = PH_BLINK;
          end
          PH_BLINK: begin
            light_main = {2'b00, light_blink[0]};
            light_aux = AUX_GO;
            if (light_blink >= BLINK_LAST) begin
              light_phase = PH_YELLOW;
              light_blink = BLINK_FIRST;
            end else begin
              light_blink = light_blink + 1'b1;
            end
          end
          default: begin
            light_main = MAIN_YELLOW;
            light_aux = AUX_YELLOW;
            light_phase = PH_RED;
          end
        endcase
      end else begin
        light_countdown = light_countdown - 1'b1;
      end
    end
    r.main_lamps = light_main;
    r.aux_lamps_n = light_aux;
    r.phase = light_phase;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic [DurW-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return DurW'($urandom_range(6, 40));
    return DurW'($urandom_range(1, 5));
  endfunction

  task automatic write_light_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_START) begin
      light_durs[idx] = data;
      // The start delay only reloads the countdown before the first phase change.
      if (idx == REG_START && light_aux == AUX_IDLE) begin
        light_countdown = (data == '0) ? DurW'(1) : data;
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_lights_idle();
    do @(negedge clk); while (tick_q.size() != 0 || in_valid || lamp_expect_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic queue_random_ticks(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      tick_q.push_back($urandom_range(0, 6) != 0);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_tick <= tick_q.pop_front();
        in_valid <= 1'b1;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_expect_q.size() == 0) begin
        errors++;
        $display("%0t: lamp beat with no expectation, main_lamps %0d phase %0d", $time,
                 out_main_lamps, out_phase);
      end else begin
        lamp_want = lamp_expect_q.pop_front();
        check_field("main_lamps", lamp_want.main_lamps, out_main_lamps);
        check_field("aux_lamps_n", lamp_want.aux_lamps_n, out_aux_lamps_n);
        check_field("phase", lamp_want.phase, out_phase);
        check_field("changed", {2'b00, lamp_want.changed}, {2'b00, out_changed});
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      lamp_expect_q.push_back(step_light(in_tick));
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("traffic_light_phase_sequencer_top_tb NOT OK");
    $finish;
  end

  initial begin
    light_durs[REG_RED] = RST_RED;
    light_durs[REG_RED_YELLOW] = RST_RED_YELLOW;
    light_durs[REG_GREEN] = RST_GREEN;
    light_durs[REG_BLINK_STEP] = RST_BLINK_STEP;
    light_durs[REG_YELLOW] = RST_YELLOW;
    light_durs[REG_START] = RST_START;
    light_phase = PH_RED;
    light_countdown = RST_START;
    light_blink = BLINK_FIRST;
    light_main = MAIN_OFF;
    light_aux = AUX_IDLE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes before the first change: spare indexes are ignored and the start delay reloads.
    gaps_on = 1'b1;
    write_light_reg(REG_SPARE_LO, 16'hFFFF);
    write_light_reg(REG_SPARE_HI, 16'h0000);
    write_light_reg(REG_START, 16'hFFFF);
    write_light_reg(REG_START, 16'd3);
    write_light_reg(REG_RED, 16'd0);
    write_light_reg(REG_RED_YELLOW, 16'd1);
    write_light_reg(REG_GREEN, 16'd2);
    write_light_reg(REG_BLINK_STEP, 16'd0);
    write_light_reg(REG_YELLOW, 16'd1);
    for (int i = 0; i < DIRECTED_BEATS; i++) begin
      tick_q.push_back(DIRECTED_TICKS[i]);
    end
    wait_lights_idle();
    write_light_reg(REG_START, 16'd0);
    for (int i = 0; i < 3; i++) begin
      tick_q.push_back(1'b1);
    end

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      wait_lights_idle();
      gaps_on = (p != 4);
      for (int i = REG_RED; i <= REG_YELLOW; i++) begin
        if (p == 6) begin
          write_light_reg(CfgIdxW'(i), 16'd0);
        end else if ($urandom_range(0, 1) == 1) begin
          write_light_reg(CfgIdxW'(i), pick_duration());
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        write_light_reg(REG_START, DurW'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_light_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                        DurW'($urandom_range(0, 65535)));
      end
      if (p % 3 == 1) begin
        queue_random_ticks(PHASE_BEATS / 2);
        wait_lights_idle();
        queue_random_ticks(PHASE_BEATS / 2);
      end else begin
        queue_random_ticks(PHASE_BEATS);
      end
    end

    wait_lights_idle();
    gaps_on = 1'b0;
    for (int i = REG_RED; i <= REG_START; i++) begin
      write_light_reg(CfgIdxW'(i), 16'hFFFF);
    end
    queue_random_ticks(50);
    wait_lights_idle();
    repeat (5) @(negedge clk);
    if (errors == 0 && lamp_expect_q.size() == 0) begin
      $display("traffic_light_phase_sequencer_top_tb OK");
    end else begin
      $display("traffic_light_phase_sequencer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
